// ===== rtl/core/rgba_pixel_compositing_unit_macros.svh =====
// ----------------------------------------------------------------------------
// RGBA pixel compositing unit - assertion macros
// Shared assertion wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef RGBA_PIXEL_COMPOSITING_UNIT_MACROS_SVH
`define RGBA_PIXEL_COMPOSITING_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define RPCU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RPCU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rpcu_pkg.sv =====
// ----------------------------------------------------------------------------
// RGBA pixel compositing unit - package
// Channel widths, operation and register codes, shared arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpcu_pkg;

  localparam int ChanBits = 8;
  localparam int PixBits  = 4 * ChanBits;
  localparam int OpBits   = 3;
  localparam int CfgIdxBits = 2;
  localparam logic [ChanBits-1:0] ChanMax = {ChanBits{1'b1}};

  localparam logic [PixBits-1:0] MaskKeyReset = '0;
  localparam logic [PixBits-1:0] TintReset    = {PixBits{1'b1}};

  typedef enum logic [OpBits-1:0] {
    OP_MASK      = 3'd0,
    OP_INV_ALPHA = 3'd1,
    OP_MOD_SRC   = 3'd2,
    OP_MOD_TINT  = 3'd3,
    OP_BLEND     = 3'd4
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_MASK_KEY = 2'd0,
    CFG_TINT     = 2'd1
  } cfg_idx_e;

  typedef logic [ChanBits-1:0] chan_t;
  typedef logic [2*ChanBits-1:0] prod_t;

  // floor(x / 255) for x below 65280: (x + (x >> 8) + 1) >> 8
  function automatic chan_t div255(input prod_t x);
    logic [2*ChanBits:0] t;
    begin
      t = {1'b0, x} + {{(ChanBits+1){1'b0}}, x[2*ChanBits-1:ChanBits]} + 17'd1;
      return t[2*ChanBits-1:ChanBits];
    end
  endfunction

  // a*b/255 rounded to nearest
  function automatic chan_t modulate(input chan_t a, input chan_t b);
    prod_t p;
    begin
      p = prod_t'(a * b) + prod_t'(ChanMax >> 1);
      return div255(p);
    end
  endfunction

endpackage

// ===== rtl/core/rpcu_if.sv =====
// ----------------------------------------------------------------------------
// RGBA pixel compositing unit - stream interfaces
// Request channel (canvas, brush, operation) and result pixel channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rpcu_in_if;
  logic                                valid;
  logic                                ready;
  logic [rpcu_pkg::OpBits-1:0]   operation;
  logic [rpcu_pkg::ChanBits-1:0] dst_red;
  logic [rpcu_pkg::ChanBits-1:0] dst_green;
  logic [rpcu_pkg::ChanBits-1:0] dst_blue;
  logic [rpcu_pkg::ChanBits-1:0] dst_alpha;
  logic [rpcu_pkg::ChanBits-1:0] src_red;
  logic [rpcu_pkg::ChanBits-1:0] src_green;
  logic [rpcu_pkg::ChanBits-1:0] src_blue;
  logic [rpcu_pkg::ChanBits-1:0] src_alpha;

  modport source (
    output valid, operation, dst_red, dst_green, dst_blue, dst_alpha,
           src_red, src_green, src_blue, src_alpha,
    input  ready
  );
  modport sink (
    input  valid, operation, dst_red, dst_green, dst_blue, dst_alpha,
           src_red, src_green, src_blue, src_alpha,
    output ready
  );
endinterface

interface rpcu_out_if;
  logic                                valid;
  logic                                ready;
  logic [rpcu_pkg::ChanBits-1:0] out_red;
  logic [rpcu_pkg::ChanBits-1:0] out_green;
  logic [rpcu_pkg::ChanBits-1:0] out_blue;
  logic [rpcu_pkg::ChanBits-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

// ===== rtl/core/rgba_pixel_compositing_unit.sv =====
// ----------------------------------------------------------------------------
// RGBA pixel compositing unit
// Per-pixel RGBA8 mask, alpha invert, modulate and blend-over.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_i      in   valid/ready    operation, dst_{r,g,b,a}, src_{r,g,b,a}
//  out_o     out  valid/ready    out_{red,green,blue,alpha}
//  cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (no read-back)
//
//  Result becomes valid after the request passes the input register, then
//  the result register. One request per cycle sustained while out_o is ready.
//  Per-channel 8x8 multiplies and a divide-by-255 sit between the registers.
//  Reset clears both valid flags and loads the register reset values.
//  A stalled result holds; a request is still taken while the input register
//  is empty, or while the result register is empty or being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgba_pixel_compositing_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  rpcu_in_if.sink                              in_i,
  rpcu_out_if.source                           out_o,
  input  logic                                 cfg_we_i,
  input  logic [rpcu_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [rpcu_pkg::PixBits-1:0]    cfg_data_i
);

  // configuration
  logic [rpcu_pkg::PixBits-1:0] key_q;
  logic [rpcu_pkg::PixBits-1:0] tint_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= rpcu_pkg::MaskKeyReset;
      tint_q <= rpcu_pkg::TintReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpcu_pkg::CFG_MASK_KEY: key_q  <= cfg_data_i;
        rpcu_pkg::CFG_TINT:     tint_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                                 s1_valid_q;
  logic [rpcu_pkg::OpBits-1:0]    op_q;
  rpcu_pkg::chan_t                dst_q [4];
  rpcu_pkg::chan_t                src_q [4];
  logic                                 s1_adv;
  logic                                 in_accept;

  assign s1_adv    = !out_o.valid || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= in_i.operation;
      dst_q[0] <= in_i.dst_red;
      dst_q[1] <= in_i.dst_green;
      dst_q[2] <= in_i.dst_blue;
      dst_q[3] <= in_i.dst_alpha;
      src_q[0] <= in_i.src_red;
      src_q[1] <= in_i.src_green;
      src_q[2] <= in_i.src_blue;
      src_q[3] <= in_i.src_alpha;
    end
  end

  // datapath
  rpcu_pkg::chan_t key_ch  [4];
  rpcu_pkg::chan_t tint_ch [4];
  rpcu_pkg::chan_t mod_src [4];
  rpcu_pkg::chan_t mod_tint[4];
  rpcu_pkg::chan_t blend   [3];
  rpcu_pkg::chan_t res_d   [4];
  rpcu_pkg::chan_t fac;
  rpcu_pkg::chan_t fac_inv;
  logic [rpcu_pkg::ChanBits+1:0] fac_sum;
  logic                                key_hit;

  // R sits in the top byte of the packed registers
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key_ch[i]  = key_q[(3-i)*rpcu_pkg::ChanBits +: rpcu_pkg::ChanBits];
      tint_ch[i] = tint_q[(3-i)*rpcu_pkg::ChanBits +: rpcu_pkg::ChanBits];
      mod_src[i]  = rpcu_pkg::modulate(dst_q[i], src_q[i]);
      mod_tint[i] = rpcu_pkg::modulate(dst_q[i], tint_ch[i]);
    end
  end

  assign key_hit = (dst_q[0] == key_ch[0]) && (dst_q[1] == key_ch[1]) &&
                   (dst_q[2] == key_ch[2]) && (dst_q[3] == key_ch[3]);

  // f = min(255, sa + 255 - da); only used when da is nonzero
  assign fac_sum = {2'b00, src_q[3]} + {2'b00, rpcu_pkg::ChanMax}
                 - {2'b00, dst_q[3]};
  assign fac     = (fac_sum > {2'b00, rpcu_pkg::ChanMax}) ? rpcu_pkg::ChanMax
                 : fac_sum[rpcu_pkg::ChanBits-1:0];
  assign fac_inv = rpcu_pkg::ChanMax - fac;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      blend[i] = rpcu_pkg::div255(rpcu_pkg::prod_t'(dst_q[i] * fac_inv)
                                + rpcu_pkg::prod_t'(src_q[i] * fac));
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res_d[i] = dst_q[i];
    end
    case (op_q)
      rpcu_pkg::OP_MASK: begin
        for (int i = 0; i < 4; i++) begin
          res_d[i] = key_hit ? rpcu_pkg::ChanMax : '0;
        end
      end
      rpcu_pkg::OP_INV_ALPHA: begin
        res_d[3] = rpcu_pkg::ChanMax - dst_q[3];
      end
      rpcu_pkg::OP_MOD_SRC: begin
        for (int i = 0; i < 4; i++) begin
          res_d[i] = mod_src[i];
        end
      end
      rpcu_pkg::OP_MOD_TINT: begin
        for (int i = 0; i < 4; i++) begin
          res_d[i] = mod_tint[i];
        end
      end
      rpcu_pkg::OP_BLEND: begin
        if (src_q[3] == '0) begin
          // transparent brush: canvas stays
        end else if (dst_q[3] == '0) begin
          for (int i = 0; i < 4; i++) begin
            res_d[i] = src_q[i];
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            res_d[i] = blend[i];
          end
          res_d[3] = (src_q[3] > dst_q[3]) ? src_q[3] : dst_q[3];
        end
      end
      default: ;
    endcase
  end

  // result register
  logic            out_valid_q;
  rpcu_pkg::chan_t res_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      for (int i = 0; i < 4; i++) begin
        res_q[i] <= res_d[i];
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_red   = res_q[0];
  assign out_o.out_green = res_q[1];
  assign out_o.out_blue  = res_q[2];
  assign out_o.out_alpha = res_q[3];

endmodule

// ===== rtl/core/rpcu_checker.sv =====
// ----------------------------------------------------------------------------
// RGBA pixel compositing unit - port checker
// Watches the top-level handshakes and tracks requests in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgba_pixel_compositing_unit_macros.svh"

module rpcu_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [rpcu_pkg::PixBits-1:0] out_pix_i
);

  logic [1:0] inflight_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 2'd1;
    end
  end

  `RPCU_ASSERT(a_hold_valid, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `RPCU_ASSERT(a_hold_data, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_pix_i), "result changed while stalled")
  `RPCU_ASSERT(a_depth, clk_i, rst_ni, inflight_q <= 2'd2 && (!out_valid_i || inflight_q != 2'd0), "requests in flight out of range")
  `RPCU_ASSERT(a_no_block, clk_i, rst_ni, !out_valid_i |-> in_ready_i, "request refused with empty result register")
  `RPCU_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind rgba_pixel_compositing_unit rpcu_checker u_rpcu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pix_i   ({out_o.out_red, out_o.out_green, out_o.out_blue, out_o.out_alpha})
);
